FILE: rtl/mrisc_pkg.sv
// ---------------------------------------------------------------------------
// mrisc_pkg
// Shared constants, instruction decode and execute-stage types for the
// 16-bit-instruction step core.
// ---------------------------------------------------------------------------
package mrisc_pkg;

   localparam int INSTR_DEPTH = 256;
   localparam int DATA_DEPTH  = 256;
   localparam int REG_COUNT   = 8;
   localparam int DATA_WIDTH  = 8;

   localparam int IADDR_W = $clog2(INSTR_DEPTH);
   localparam int DADDR_W = $clog2(DATA_DEPTH);
   localparam int REG_W   = $clog2(REG_COUNT);

   localparam int PC_W    = 8;
   localparam int ADDR_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int INSTR_W = 16;
   localparam int IMM_W   = 6;
   localparam int JADDR_W = 7;

   localparam int REQ_W = 24;
   localparam int RSP_W = 40;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic [3:0] OP_RTYPE = 4'd0;
   localparam logic [3:0] OP_JUMP  = 4'd2;
   localparam logic [3:0] OP_ADDI  = 4'd4;
   localparam logic [3:0] OP_BEQ   = 4'd8;
   localparam logic [3:0] OP_LW    = 4'd11;
   localparam logic [3:0] OP_SW    = 4'd15;

   localparam logic [2:0] FN_ADD = 3'd0;
   localparam logic [2:0] FN_SUB = 3'd2;
   localparam logic [2:0] FN_AND = 3'd4;
   localparam logic [2:0] FN_OR  = 3'd5;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [REG_W-1:0]   rs;
      logic [REG_W-1:0]   rt;
      logic [REG_W-1:0]   rd;
      logic [2:0]         funct;
      logic [IMM_W-1:0]   imm;
      logic [JADDR_W-1:0] addr;
   } instr_fields_type;

   typedef struct packed {
      logic [PC_W-1:0]       next_pc;
      logic                  reg_we;
      logic [REG_W-1:0]      reg_idx;
      logic [DATA_WIDTH-1:0] reg_val;
      logic                  mem_we;
      logic                  mem_re;
      logic [ADDR_W-1:0]     mem_addr;
      logic [DATA_WIDTH-1:0] mem_val;
   } exec_type;

   function automatic instr_fields_type decode(input logic [INSTR_W-1:0] w);
      instr_fields_type f;
      f.opcode = w[15:12];
      f.rs     = w[11:9];
      f.rt     = w[8:6];
      f.rd     = w[5:3];
      f.funct  = w[2:0];
      f.imm    = w[IMM_W-1:0];
      f.addr   = w[JADDR_W-1:0];
      return f;
   endfunction

endpackage

FILE: rtl/mini_risc_instruction_step.sv
// ---------------------------------------------------------------------------
// mini_risc_instruction_step
// Tiny 16-bit-instruction core: load requests fill instruction memory,
// step requests execute the instruction at the pc, one per cycle while the response is not stalled.
// ---------------------------------------------------------------------------
// Response: the request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the response is not stalled; the next
// instruction word is prefetched from instruction memory on the edge the current one executes.
// Reset: pc, register file and data memory valid bits clear at once;
// instruction memory is undefined until loaded.
// ---------------------------------------------------------------------------
module mini_risc_instruction_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // load_address[7:0], instruction_word[23:8]
   input  logic [mrisc_pkg::REQ_W-1:0]   req_tdata,
   // command[0]
   input  logic [0:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // next_pc[7:0], reg_written[8], reg_index[11:9], reg_value[19:12],
   // mem_written[20], mem_address[28:21], mem_value[36:29], zero[39:37]
   output logic [mrisc_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int DW = mrisc_pkg::DATA_WIDTH;

   logic                            req_accept;
   logic                            s1_adv;

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_cmd_ff;
   logic [mrisc_pkg::ADDR_W-1:0]    s1_laddr_ff;
   logic [mrisc_pkg::INSTR_W-1:0]   s1_word_ff;

   logic [mrisc_pkg::PC_W-1:0]      pc_ff;
   logic [mrisc_pkg::INSTR_W-1:0]   instr_ff;
   logic [mrisc_pkg::INSTR_W-1:0]   imem_mem [mrisc_pkg::INSTR_DEPTH];

   logic [DW-1:0]                   regs_ff [mrisc_pkg::REG_COUNT];

   logic [DW-1:0]                   dmem_mem [mrisc_pkg::DATA_DEPTH];
   logic [mrisc_pkg::DATA_DEPTH-1:0] dvalid_ff;
   logic [DW-1:0]                   dmem_q_ff;
   logic                            dvalid_q_ff;
   logic [DW-1:0]                   lw_data;

   logic                            wb_pending_ff, wb_pending_in;
   logic [mrisc_pkg::REG_W-1:0]     wb_idx_ff;

   logic                            s2_valid_ff, s2_valid_in;
   mrisc_pkg::exec_type             s2_ff;

   mrisc_pkg::instr_fields_type     fields;
   logic [DW-1:0]                   src_a, src_b;
   mrisc_pkg::exec_type             exec_res;
   logic [mrisc_pkg::BYTE_W-1:0]    rsp_reg_value;

   logic [mrisc_pkg::DADDR_W-1:0]   daddr;
   logic [mrisc_pkg::IADDR_W-1:0]   load_idx;
   logic [mrisc_pkg::IADDR_W-1:0]   pc_idx;
   logic [mrisc_pkg::IADDR_W-1:0]   fetch_idx;

   // handshake
   assign req_accept = req_tvalid && req_tready;
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   assign wb_pending_in = s1_adv && exec_res.mem_re;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         wb_pending_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         wb_pending_ff <= wb_pending_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff   <= req_tuser[0];
         s1_laddr_ff <= req_tdata[7:0];
         s1_word_ff  <= req_tdata[23:8];
      end
   end

   // operand read with forwarding of a pending load
   assign lw_data = dvalid_q_ff ? dmem_q_ff : '0;
   assign fields  = mrisc_pkg::decode(instr_ff);
   assign src_a   = (wb_pending_ff && wb_idx_ff == fields.rs) ? lw_data : regs_ff[fields.rs];
   assign src_b   = (wb_pending_ff && wb_idx_ff == fields.rt) ? lw_data : regs_ff[fields.rt];

   mrisc_exec u_exec (
      .command (s1_cmd_ff),
      .instr   (instr_ff),
      .pc      (pc_ff),
      .src_a   (src_a),
      .src_b   (src_b),
      .result  (exec_res)
   );

   // pc
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (s1_adv) begin
         pc_ff <= exec_res.next_pc;
      end
   end

   // instruction memory; instr_ff always holds the word at pc
   assign load_idx  = s1_laddr_ff[mrisc_pkg::IADDR_W-1:0];
   assign pc_idx    = pc_ff[mrisc_pkg::IADDR_W-1:0];
   assign fetch_idx = exec_res.next_pc[mrisc_pkg::IADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         if (s1_cmd_ff == mrisc_pkg::CMD_LOAD) begin
            imem_mem[load_idx] <= s1_word_ff;
            if (load_idx == pc_idx) begin
               instr_ff <= s1_word_ff;
            end
         end else begin
            instr_ff <= imem_mem[fetch_idx];
         end
      end
   end

   // register file; later instruction wins over load writeback
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mrisc_pkg::REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (wb_pending_ff) begin
            regs_ff[wb_idx_ff] <= lw_data;
         end
         if (s1_adv && exec_res.reg_we && !exec_res.mem_re) begin
            regs_ff[exec_res.reg_idx] <= exec_res.reg_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         wb_idx_ff <= exec_res.reg_idx;
      end
   end

   // data memory
   assign daddr = exec_res.mem_addr[mrisc_pkg::DADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (s1_adv && exec_res.mem_we) begin
         dmem_mem[daddr] <= exec_res.mem_val;
      end
      if (s1_adv && exec_res.mem_re) begin
         dmem_q_ff <= dmem_mem[daddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff   <= '0;
         dvalid_q_ff <= 1'b0;
      end else begin
         if (s1_adv && exec_res.mem_we) begin
            dvalid_ff[daddr] <= 1'b1;
         end
         if (s1_adv && exec_res.mem_re) begin
            dvalid_q_ff <= dvalid_ff[daddr];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_ff <= exec_res;
      end
   end

   assign rsp_reg_value = s2_ff.mem_re ? lw_data[mrisc_pkg::BYTE_W-1:0]
                                       : s2_ff.reg_val[mrisc_pkg::BYTE_W-1:0];

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {3'b000,
                        s2_ff.mem_val[mrisc_pkg::BYTE_W-1:0],
                        s2_ff.mem_addr,
                        s2_ff.mem_we,
                        rsp_reg_value,
                        s2_ff.reg_idx,
                        s2_ff.reg_we,
                        s2_ff.next_pc};

   // assertions
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && s2_valid_ff && !rsp_tready))
      else $error("request stalled without a blocked response");

   a_wb_matches: assert property (@(posedge clock) disable iff (reset)
      wb_pending_ff |-> (s2_valid_ff && s2_ff.mem_re && s2_ff.reg_idx == wb_idx_ff))
      else $error("load writeback without matching response");

   a_pc_update: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (pc_ff == $past(exec_res.next_pc)))
      else $error("pc does not follow executed request");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !(s2_ff.mem_we && s2_ff.reg_we))
      else $error("register and memory written by one request");

endmodule

FILE: rtl/mrisc_exec.sv
// ---------------------------------------------------------------------------
// mrisc_exec
// Decode and execute of one request: next pc, ALU result, register write and
// data memory read and write controls.
// ---------------------------------------------------------------------------
module mrisc_exec (
   input  logic                            command,
   input  logic [mrisc_pkg::INSTR_W-1:0]   instr,
   input  logic [mrisc_pkg::PC_W-1:0]      pc,
   input  logic [mrisc_pkg::DATA_WIDTH-1:0] src_a,
   input  logic [mrisc_pkg::DATA_WIDTH-1:0] src_b,
   output mrisc_pkg::exec_type             result
);

   mrisc_pkg::instr_fields_type f;
   logic [mrisc_pkg::ADDR_W-1:0] ea;

   assign f  = mrisc_pkg::decode(instr);
   assign ea = src_a[mrisc_pkg::ADDR_W-1:0]
             + {{(mrisc_pkg::ADDR_W-mrisc_pkg::IMM_W){1'b0}}, f.imm};

   always_comb begin
      result         = '0;
      result.next_pc = pc;
      if (command == mrisc_pkg::CMD_STEP) begin
         result.next_pc = pc + 1'b1;
         unique case (f.opcode)
            mrisc_pkg::OP_RTYPE: begin
               result.reg_we  = 1'b1;
               result.reg_idx = f.rd;
               case (f.funct)
                  mrisc_pkg::FN_ADD: result.reg_val = src_a + src_b;
                  mrisc_pkg::FN_SUB: result.reg_val = src_a - src_b;
                  mrisc_pkg::FN_AND: result.reg_val = src_a & src_b;
                  mrisc_pkg::FN_OR:  result.reg_val = src_a | src_b;
                  default:           result.reg_val = src_a + src_b;
               endcase
            end
            mrisc_pkg::OP_JUMP: begin
               result.next_pc = mrisc_pkg::PC_W'({f.addr, 1'b0});
            end
            mrisc_pkg::OP_ADDI: begin
               result.reg_we  = 1'b1;
               result.reg_idx = f.rt;
               result.reg_val = src_a + mrisc_pkg::DATA_WIDTH'(f.imm);
            end
            mrisc_pkg::OP_BEQ: begin
            end
            mrisc_pkg::OP_LW: begin
               result.reg_we   = 1'b1;
               result.reg_idx  = f.rt;
               result.mem_re   = 1'b1;
               result.mem_addr = ea;
            end
            mrisc_pkg::OP_SW: begin
               result.mem_we   = 1'b1;
               result.mem_addr = ea;
               result.mem_val  = src_b;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: tb/mini_risc_instruction_step_test.sv
// ---------------------------------------------------------------------------
// mini_risc_instruction_step_test
// Self-checking bench for the step core: fills instruction memory with
// load requests, runs short programs with step requests and checks every
// response against a shadow copy of pc, registers and memories.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mini_risc_instruction_step_test;

   localparam logic [3:0] OP_SPARE = 4'd1;
   localparam logic [2:0] FN_OTHER = 3'd7;
   localparam int REQUEST_TARGET   = 1950;

   typedef struct packed {
      logic [7:0] mem_value;
      logic [7:0] mem_address;
      logic       mem_written;
      logic [7:0] reg_value;
      logic [2:0] reg_index;
      logic       reg_written;
      logic [7:0] next_pc;
   } step_result_type;

   class core_shadow_type;
      logic [7:0]      pc;
      logic [7:0]      regs [8];
      logic [7:0]      dmem [256];
      logic [15:0]     imem [256];
      bit              loaded [256];
      step_result_type pending_results [$];
      int              accepted;
      int              mismatches;

      function new();
         pc = '0;
         foreach (regs[i]) regs[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         foreach (imem[i]) imem[i] = '0;
         foreach (loaded[i]) loaded[i] = 0;
         accepted = 0;
         mismatches = 0;
      endfunction

      function void record_request(logic cmd, logic [7:0] load_addr, logic [15:0] word);
         step_result_type r;
         logic [15:0]     ins;
         logic [2:0]      rs, rt, rd;
         logic [7:0]      a, b, ea, v;
         r = '0;
         r.next_pc = pc;
         accepted++;
         if (cmd == mrisc_pkg::CMD_LOAD) begin
            imem[load_addr] = word;
            loaded[load_addr] = 1;
         end else begin
            ins = imem[pc];
            rs  = ins[11:9];
            rt  = ins[8:6];
            rd  = ins[5:3];
            a   = regs[rs];
            b   = regs[rt];
            ea  = a + 8'(ins[5:0]);
            r.next_pc = pc + 8'd1;
            case (ins[15:12])
               mrisc_pkg::OP_RTYPE: begin
                  case (ins[2:0])
                     mrisc_pkg::FN_SUB: v = a - b;
                     mrisc_pkg::FN_AND: v = a & b;
                     mrisc_pkg::FN_OR:  v = a | b;
                     default:           v = a + b;
                  endcase
                  regs[rd] = v;
                  r.reg_written = 1;
                  r.reg_index = rd;
                  r.reg_value = v;
               end
               mrisc_pkg::OP_JUMP: r.next_pc = {ins[6:0], 1'b0};
               mrisc_pkg::OP_ADDI: begin
                  regs[rt] = ea;
                  r.reg_written = 1;
                  r.reg_index = rt;
                  r.reg_value = ea;
               end
               mrisc_pkg::OP_LW: begin
                  regs[rt] = dmem[ea];
                  r.reg_written = 1;
                  r.reg_index = rt;
                  r.reg_value = dmem[ea];
                  r.mem_address = ea;
               end
               mrisc_pkg::OP_SW: begin
                  dmem[ea] = b;
                  r.mem_written = 1;
                  r.mem_address = ea;
                  r.mem_value = b;
               end
               default: ;
            endcase
            pc = r.next_pc;
         end
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [mrisc_pkg::RSP_W-1:0] d);
         step_result_type got, exp;
         got = step_result_type'(d[36:0]);
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: %h", got);
            return;
         end
         exp = pending_results.pop_front();
         if (got.next_pc !== exp.next_pc || got.reg_written !== exp.reg_written ||
             got.reg_index !== exp.reg_index || got.reg_value !== exp.reg_value ||
             got.mem_written !== exp.mem_written ||
             got.mem_address !== exp.mem_address || got.mem_value !== exp.mem_value) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch expected: pc=%h rw=%b ri=%0d rv=%h mw=%b ma=%h mv=%h",
                        exp.next_pc, exp.reg_written, exp.reg_index, exp.reg_value,
                        exp.mem_written, exp.mem_address, exp.mem_value);
               $display("         actual:   pc=%h rw=%b ri=%0d rv=%h mw=%b ma=%h mv=%h",
                        got.next_pc, got.reg_written, got.reg_index, got.reg_value,
                        got.mem_written, got.mem_address, got.mem_value);
            end
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [mrisc_pkg::REQ_W-1:0]   req_tdata;
   logic [0:0]                    req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [mrisc_pkg::RSP_W-1:0]   rsp_tdata;

   int send_idle_pct;
   int rsp_stall_pct;

   core_shadow_type core = new();

   mini_risc_instruction_step uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         core.check_response(rsp_tdata);
   end

   task automatic send_request(logic cmd, logic [7:0] load_addr, logic [15:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {word, load_addr};
      do @(posedge clock); while (!req_tready);
      core.record_request(cmd, load_addr, word);
   endtask

   // never fetch an unloaded entry
   task automatic step_once();
      if (!core.loaded[core.pc])
         send_request(mrisc_pkg::CMD_LOAD, core.pc, random_instruction());
      send_request(mrisc_pkg::CMD_STEP, 8'($urandom), 16'($urandom));
   endtask

   function automatic logic [15:0] enc_i(logic [3:0] op, logic [2:0] rs, logic [2:0] rt,
                                         logic [5:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [15:0] enc_r(logic [2:0] rs, logic [2:0] rt, logic [2:0] rd,
                                         logic [2:0] fn);
      return {mrisc_pkg::OP_RTYPE, rs, rt, rd, fn};
   endfunction

   function automatic logic [15:0] random_instruction();
      int         pick;
      logic [3:0] op;
      pick = $urandom_range(99);
      if (pick < 30)      op = mrisc_pkg::OP_RTYPE;
      else if (pick < 50) op = mrisc_pkg::OP_ADDI;
      else if (pick < 62) op = mrisc_pkg::OP_LW;
      else if (pick < 74) op = mrisc_pkg::OP_SW;
      else if (pick < 82) op = mrisc_pkg::OP_JUMP;
      else if (pick < 88) op = mrisc_pkg::OP_BEQ;
      else begin
         do op = 4'($urandom_range(15));
         while (op inside {mrisc_pkg::OP_RTYPE, mrisc_pkg::OP_JUMP, mrisc_pkg::OP_ADDI,
                           mrisc_pkg::OP_BEQ, mrisc_pkg::OP_LW, mrisc_pkg::OP_SW});
      end
      return {op, 12'($urandom_range(4095))};
   endfunction

   task automatic run_directed();
      logic [15:0] prog [14];
      logic [7:0]  addr;
      prog[0]  = enc_i(mrisc_pkg::OP_ADDI, 3'd0, 3'd1, 6'd63);
      prog[1]  = enc_i(mrisc_pkg::OP_ADDI, 3'd1, 3'd2, 6'd63);
      prog[2]  = enc_r(3'd1, 3'd2, 3'd3, mrisc_pkg::FN_ADD);
      prog[3]  = enc_r(3'd1, 3'd2, 3'd4, mrisc_pkg::FN_SUB);
      prog[4]  = enc_r(3'd3, 3'd4, 3'd5, mrisc_pkg::FN_AND);
      prog[5]  = enc_r(3'd3, 3'd4, 3'd6, mrisc_pkg::FN_OR);
      prog[6]  = enc_r(3'd2, 3'd3, 3'd7, FN_OTHER);
      prog[7]  = enc_i(mrisc_pkg::OP_SW, 3'd7, 3'd4, 6'd63);
      prog[8]  = enc_i(mrisc_pkg::OP_LW, 3'd7, 3'd0, 6'd63);
      prog[9]  = {mrisc_pkg::OP_BEQ, 12'hfff};
      prog[10] = {OP_SPARE, 12'hfff};
      prog[11] = {mrisc_pkg::OP_JUMP, 5'd31, 7'd127};
      // wrapping add, then store address and pc both wrap
      prog[12] = enc_i(mrisc_pkg::OP_ADDI, 3'd4, 3'd7, 6'd63);
      prog[13] = enc_i(mrisc_pkg::OP_SW, 3'd4, 3'd6, 6'd63);
      for (int i = 0; i < 14; i++) begin
         addr = (i < 12) ? 8'(i) : 8'(242 + i);
         send_request(mrisc_pkg::CMD_LOAD, addr, prog[i]);
      end
      for (int i = 0; i < 14; i++)
         send_request(mrisc_pkg::CMD_STEP, 8'hff, 16'hffff);
   endtask

   task automatic run_program();
      int         len, steps, pick;
      logic [7:0] base;
      len   = $urandom_range(3, 12);
      steps = $urandom_range(4, 24);
      base  = core.pc;
      for (int i = 0; i < len; i++)
         send_request(mrisc_pkg::CMD_LOAD, base + 8'(i), random_instruction());
      for (int i = 0; i < steps; i++) begin
         pick = $urandom_range(99);
         // overwrite the word at or after the pc around prefetch
         if (pick < 3)
            send_request(mrisc_pkg::CMD_LOAD, core.pc, random_instruction());
         else if (pick < 6)
            send_request(mrisc_pkg::CMD_LOAD, core.pc + 8'd1, random_instruction());
         else if (pick < 10)
            send_request(mrisc_pkg::CMD_LOAD, 8'($urandom), 16'($urandom));
         step_once();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = mrisc_pkg::CMD_LOAD;
      send_idle_pct = 16;
      rsp_stall_pct = 46;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 16; rsp_stall_pct = 46; end
            1: begin send_idle_pct = 46; rsp_stall_pct = 16; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         while (core.accepted < REQUEST_TARGET * (phase + 1) / 3)
            run_program();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (core.pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (core.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
